FILE: rtl/core/obbt_pkg.sv
// ----------------------------------------------------------------------------
// obbt_pkg
// Shared types, constants and small lookup functions for the box overlap core.
// ----------------------------------------------------------------------------
package obbt_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int QUAT_WIDTH_DEF  = 16;
	localparam int OUT_W           = 8;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	localparam logic [3:0] AXIS_LAST  = 4'd14;
	localparam logic [4:0] MAT_LAST   = 5'd8;
	localparam logic [4:0] CORN_LAST  = 5'd7;
	localparam logic [4:0] XPROD_LAST = 5'd2;
	localparam logic [4:0] PROJ_ISSUE = 5'd16;
	localparam logic [4:0] PROJ_LAST  = 5'd17;

	localparam logic [1:0] Q_W = 2'd0;
	localparam logic [1:0] Q_X = 2'd1;
	localparam logic [1:0] Q_Y = 2'd2;
	localparam logic [1:0] Q_Z = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic       capture;
		logic       mat_en;
		logic       half_en;
		logic       corn_en;
		logic       store_ref;
		logic       axis_en;
		logic       hit_init;
		logic       proj_issue;
		logic       eval_en;
		logic       result_load;
		logic [4:0] cnt;
		logic [3:0] axis;
	} obbt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_test;
		logic axis_zero;
		logic overlap;
	} obbt_sts_t;

	// rotation entry = +/-(base - 2*(a*b +/- c*d)), base one on the diagonal, else zero
	typedef struct packed {
		logic [1:0] ia;
		logic [1:0] ib;
		logic [1:0] ic;
		logic [1:0] id;
		logic       sub;
		logic       diag;
		logic       neg;
	} obbt_msel_t;

	function automatic obbt_msel_t mat_sel(input logic [3:0] e);
		obbt_msel_t s;
		s = '0;
		case (e)
			4'd0: s = '{Q_Y, Q_Y, Q_Z, Q_Z, 1'b0, 1'b1, 1'b0};
			4'd1: s = '{Q_X, Q_Y, Q_W, Q_Z, 1'b0, 1'b0, 1'b0};
			4'd2: s = '{Q_X, Q_Z, Q_W, Q_Y, 1'b1, 1'b0, 1'b0};
			4'd3: s = '{Q_X, Q_Y, Q_W, Q_Z, 1'b1, 1'b0, 1'b0};
			4'd4: s = '{Q_X, Q_X, Q_Z, Q_Z, 1'b0, 1'b1, 1'b0};
			4'd5: s = '{Q_Y, Q_Z, Q_W, Q_X, 1'b0, 1'b0, 1'b0};
			4'd6: s = '{Q_X, Q_Z, Q_W, Q_Y, 1'b0, 1'b0, 1'b1};
			4'd7: s = '{Q_Y, Q_Z, Q_W, Q_X, 1'b1, 1'b0, 1'b1};
			4'd8: s = '{Q_X, Q_X, Q_Y, Q_Y, 1'b0, 1'b1, 1'b1};
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [1:0] div3(input logic [3:0] v);
		logic [1:0] r;
		case (v)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] mod3(input logic [3:0] v);
		logic [1:0] r;
		case (v)
			4'd0, 4'd3, 4'd6: r = 2'd0;
			4'd1, 4'd4, 4'd7: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] idx3(input logic [1:0] i, input logic [1:0] k);
		return 4'({i, 1'b0}) + 4'(i) + 4'(k);
	endfunction

	function automatic logic [1:0] rot1(input logic [1:0] k);
		return (k == 2'd2) ? 2'd0 : k + 2'd1;
	endfunction

	function automatic logic [1:0] rot2(input logic [1:0] k);
		return (k == 2'd0) ? 2'd2 : k - 2'd1;
	endfunction

	// bit i set: the corner takes minus half-extent along box axis i
	function automatic logic [2:0] corner_neg(input logic [2:0] c);
		logic [2:0] r;
		case (c)
			3'd0: r = 3'b101;
			3'd1: r = 3'b100;
			3'd2: r = 3'b110;
			3'd3: r = 3'b111;
			3'd4: r = 3'b001;
			3'd5: r = 3'b000;
			3'd6: r = 3'b010;
			default: r = 3'b011;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/obb_overlap_test_core.sv
// ----------------------------------------------------------------------------
// obb_overlap_test_core
// Oriented box overlap test by separating axes, reference box held inside.
// ----------------------------------------------------------------------------
// Load word: after accept, rotation, half extents and corners are built and
//   stored as the reference before the next word can be taken.
// Test word: the box is built, then per tried axis come the 3 axis components,
//   a zero check, the 16 corner projections, pipe drain and the compare; a zero
//   axis is skipped after its check. At most 15 axes, stops at the first separating
//   one; then the result is loaded and the core idles. The shared projection unit takes one corner per cycle.
// One word in flight; a finished result waits in the output register.
// arst_n clears the controller, output valid and the reference box (all zero).
module obb_overlap_test_core
	import obbt_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// center_x, center_y, center_z, size_x, size_y, size_z,
	// quat_w, quat_x, quat_y, quat_z, zero fill
	input  logic [((6*COORD_WIDTH-3+4*QUAT_WIDTH+7)/8)*8-1:0] s_tdata,
	// cmd: 0 load reference, 1 test
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// collide, zero fill
	output logic [OUT_W-1:0] m_tdata
);

	obbt_cmd_t cmd;
	obbt_sts_t sts;
	logic      collide;

	// sequencer: owns handshakes and sweep counters
	obbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// arithmetic and box storage
	obbt_dp #(
		.COORD_WIDTH (COORD_WIDTH),
		.QUAT_WIDTH  (QUAT_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.sts     (sts),
		.collide (collide)
	);

	assign m_tdata = {{(OUT_W-1){1'b0}}, collide};

endmodule

FILE: rtl/core/obbt_ctrl.sv
// ----------------------------------------------------------------------------
// obbt_ctrl
// Sequencer: box build, reference store, axis sweep and result handoff.
// ----------------------------------------------------------------------------
module obbt_ctrl
	import obbt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output obbt_cmd_t cmd,
	input  obbt_sts_t sts
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MAT   = 10'b0000000010,
		S_HALF  = 10'b0000000100,
		S_CORN  = 10'b0000001000,
		S_STORE = 10'b0000010000,
		S_AXIS  = 10'b0000100000,
		S_ZCHK  = 10'b0001000000,
		S_PROJ  = 10'b0010000000,
		S_EVAL  = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [3:0] axis_q, axis_d;
	logic       m_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + 5'd1;
		axis_d  = axis_q;
		cmd     = '0;
		cmd.cnt  = cnt_q;
		cmd.axis = axis_q;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				cnt_d       = '0;
				if (s_tvalid) state_d = S_MAT;
			end
			S_MAT: begin
				cmd.mat_en = 1'b1;
				if (cnt_q == MAT_LAST) begin
					cnt_d   = '0;
					state_d = S_HALF;
				end
			end
			S_HALF: begin
				cmd.half_en = 1'b1;
				if (cnt_q == MAT_LAST) begin
					cnt_d   = '0;
					state_d = S_CORN;
				end
			end
			S_CORN: begin
				cmd.corn_en = 1'b1;
				if (cnt_q == CORN_LAST) begin
					cnt_d = '0;
					if (sts.is_test) begin
						cmd.hit_init = 1'b1;
						axis_d       = '0;
						state_d      = S_AXIS;
					end else begin
						state_d = S_STORE;
					end
				end
			end
			S_STORE: begin
				cmd.store_ref = 1'b1;
				state_d       = S_IDLE;
			end
			S_AXIS: begin
				cmd.axis_en = 1'b1;
				if (cnt_q == XPROD_LAST) state_d = S_ZCHK;
			end
			S_ZCHK: begin
				cnt_d = '0;
				if (!sts.axis_zero) begin
					state_d = S_PROJ;
				end else if (axis_q == AXIS_LAST) begin
					state_d = S_DONE;
				end else begin
					axis_d  = axis_q + 4'd1;
					state_d = S_AXIS;
				end
			end
			S_PROJ: begin
				cmd.proj_issue = (cnt_q < PROJ_ISSUE);
				if (cnt_q == PROJ_LAST) state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval_en = 1'b1;
				cnt_d       = '0;
				if (!sts.overlap || axis_q == AXIS_LAST) begin
					state_d = S_DONE;
				end else begin
					axis_d  = axis_q + 4'd1;
					state_d = S_AXIS;
				end
			end
			S_DONE: begin
				if (!m_valid_q || m_tready) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			axis_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
			if (cmd.result_load)  m_valid_q <= 1'b1;
			else if (m_tready)    m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;

endmodule

FILE: rtl/core/obbt_dp.sv
// ----------------------------------------------------------------------------
// obbt_dp
// Datapath: rotation, half extents, corners, candidate axes, projections.
// ----------------------------------------------------------------------------
module obbt_dp
	import obbt_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [((6*COORD_WIDTH-3+4*QUAT_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic                                s_tuser,
	input  obbt_cmd_t                           cmd,
	output obbt_sts_t                           sts,
	output logic                                collide
);

	localparam int CW     = COORD_WIDTH;
	localparam int QW     = QUAT_WIDTH;
	localparam int QFRAC  = QW - 2;
	localparam int CRW    = CW + 2;
	localparam int MW     = 2*QW + 4;
	localparam int HW     = CW + 1;
	localparam int PW     = QW + CW + 1;
	localparam int CSW    = CW + 4;
	localparam int TW     = 2*QW + 1;
	localparam int XSHIFT = (CW + 2*QW + 2 > 63) ? (CW + 2*QW + 2 - 63) : 0;
	localparam int PRW    = CRW + TW;
	localparam int PSW    = PRW + 2;

	localparam logic signed [MW-1:0]  ONE    = MW'(1) <<< (2*QFRAC);
	localparam logic signed [MW-1:0]  AX_MAX = (MW'(1) <<< (QW-1)) - MW'(1);
	localparam logic signed [MW-1:0]  AX_MIN = -AX_MAX - MW'(1);
	localparam logic signed [CSW-1:0] CR_MAX = (CSW'(1) <<< (CRW-1)) - CSW'(1);
	localparam logic signed [CSW-1:0] CR_MIN = -CR_MAX - CSW'(1);

	// captured item
	logic signed [CW-1:0]  ctr_q [3];
	logic        [CW-2:0]  siz_q [3];
	logic signed [QW-1:0]  quat_q [4];
	logic                  test_q;

	// box under build and stored reference
	logic signed [QW-1:0]  ax_q [9];
	logic signed [HW-1:0]  h_q [9];
	logic signed [CRW-1:0] cr_q [8][3];
	logic signed [QW-1:0]  ref_ax_q [9];
	logic signed [CRW-1:0] ref_cr_q [8][3];

	// axis and projection
	logic signed [TW-1:0]  t_q [3];
	logic signed [PRW-1:0] prod_s1 [3];
	logic                  valid_s1, valid_s2;
	logic [3:0]            idx_s1, idx_s2;
	logic signed [PSW-1:0] sum_s2;
	logic signed [PSW-1:0] lo_q [2];
	logic signed [PSW-1:0] hi_q [2];
	logic                  hit_q, collide_q;

	// ---- rotation entry
	obbt_msel_t            ms;
	logic signed [2*QW-1:0] pab, pcd;
	logic signed [MW-1:0]  mv, mr;
	logic signed [QW-1:0]  ax_new;

	always_comb begin
		ms  = mat_sel(cmd.cnt[3:0]);
		pab = quat_q[ms.ia] * quat_q[ms.ib];
		pcd = quat_q[ms.ic] * quat_q[ms.id];
		mv  = ms.sub ? (MW'(pab) - MW'(pcd)) : (MW'(pab) + MW'(pcd));
		mv  = mv <<< 1;
		if (ms.diag) mv = ONE - mv;
		if (ms.neg)  mv = -mv;
		mr  = (mv + (MW'(1) <<< (QFRAC-1))) >>> QFRAC;
		if (mr > AX_MAX)      ax_new = AX_MAX[QW-1:0];
		else if (mr < AX_MIN) ax_new = AX_MIN[QW-1:0];
		else                  ax_new = mr[QW-1:0];
	end

	// ---- half extent
	logic signed [PW-1:0] hp, hr;

	always_comb begin
		hp = PW'(ax_q[cmd.cnt[3:0]]) *
			PW'($signed({1'b0, siz_q[div3(cmd.cnt[3:0])]}));
		hr = (hp + (PW'(1) <<< QFRAC)) >>> (QFRAC+1);
	end

	// ---- corner, three component lanes
	logic signed [CRW-1:0] cr_new [3];
	logic signed [CSW-1:0] cv;
	logic [2:0]            cneg;

	always_comb begin
		cneg = corner_neg(cmd.cnt[2:0]);
		for (int k = 0; k < 3; k++) begin
			cv = CSW'(ctr_q[k]);
			for (int i = 0; i < 3; i++) begin
				if (cneg[i]) cv = cv - CSW'(h_q[i*3+k]);
				else         cv = cv + CSW'(h_q[i*3+k]);
			end
			if (cv > CR_MAX)      cr_new[k] = CR_MAX[CRW-1:0];
			else if (cv < CR_MIN) cr_new[k] = CR_MIN[CRW-1:0];
			else                  cr_new[k] = cv[CRW-1:0];
		end
	end

	// ---- candidate axis, one component per cycle
	logic [1:0]           kk, kp, kq, ai, bj;
	logic [3:0]           arel;
	logic signed [TW-1:0] xa, xb, t_new;

	always_comb begin
		kk   = cmd.cnt[1:0];
		kp   = rot1(kk);
		kq   = rot2(kk);
		arel = cmd.axis - 4'd6;
		ai   = div3(arel);
		bj   = mod3(arel);
		xa   = ref_ax_q[idx3(ai, kp)] * ax_q[idx3(bj, kq)];
		xb   = ref_ax_q[idx3(ai, kq)] * ax_q[idx3(bj, kp)];
		if (cmd.axis < 4'd3)
			t_new = TW'(ref_ax_q[idx3(cmd.axis[1:0], kk)]);
		else if (cmd.axis < 4'd6)
			t_new = TW'(ax_q[idx3(2'(cmd.axis - 4'd3), kk)]);
		else
			t_new = (xa - xb) >>> XSHIFT;
	end

	// ---- projection operand select
	logic signed [CRW-1:0] csel [3];

	always_comb begin
		for (int k = 0; k < 3; k++)
			csel[k] = cmd.cnt[3] ? cr_q[cmd.cnt[2:0]][k] : ref_cr_q[cmd.cnt[2:0]][k];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int k = 0; k < 3; k++) begin
				ctr_q[k] <= s_tdata[k*CW +: CW];
				siz_q[k] <= s_tdata[3*CW + k*(CW-1) +: CW-1];
			end
			for (int k = 0; k < 4; k++)
				quat_q[k] <= s_tdata[6*CW-3 + k*QW +: QW];
			test_q <= s_tuser;
		end
		if (cmd.mat_en)  ax_q[cmd.cnt[3:0]] <= ax_new;
		if (cmd.half_en) h_q[cmd.cnt[3:0]]  <= hr[HW-1:0];
		if (cmd.corn_en) begin
			for (int k = 0; k < 3; k++)
				cr_q[cmd.cnt[2:0]][k] <= cr_new[k];
		end
		if (cmd.axis_en) t_q[kk] <= t_new;
		for (int k = 0; k < 3; k++)
			prod_s1[k] <= PRW'(csel[k]) * PRW'(t_q[k]);
		idx_s1 <= cmd.cnt[3:0];
		idx_s2 <= idx_s1;
		sum_s2 <= PSW'(prod_s1[0]) + PSW'(prod_s1[1]) + PSW'(prod_s1[2]);
		if (valid_s2) begin
			if (idx_s2[2:0] == 3'd0 || sum_s2 < lo_q[idx_s2[3]]) lo_q[idx_s2[3]] <= sum_s2;
			if (idx_s2[2:0] == 3'd0 || sum_s2 > hi_q[idx_s2[3]]) hi_q[idx_s2[3]] <= sum_s2;
		end
		if (cmd.hit_init)     hit_q     <= 1'b1;
		else if (cmd.eval_en) hit_q     <= hit_q & sts.overlap;
		if (cmd.result_load)  collide_q <= hit_q;
	end

	// reference resets to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < 9; e++) ref_ax_q[e] <= '0;
			for (int c = 0; c < 8; c++)
				for (int k = 0; k < 3; k++) ref_cr_q[c][k] <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.proj_issue;
			valid_s2 <= valid_s1;
			if (cmd.store_ref) begin
				ref_ax_q <= ax_q;
				ref_cr_q <= cr_q;
			end
		end
	end

	assign sts.is_test   = (test_q == CMD_TEST);
	assign sts.axis_zero = (t_q[0] == '0) && (t_q[1] == '0) && (t_q[2] == '0);
	assign sts.overlap   = (hi_q[0] > lo_q[1]) && (hi_q[1] > lo_q[0]);
	assign collide       = collide_q;

endmodule

FILE: rtl/core/obbt_chk.sv
// ----------------------------------------------------------------------------
// obbt_chk
// Port-level checks for the overlap core, bound to the top level.
// ----------------------------------------------------------------------------
module obbt_chk
	import obbt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// one word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a word is in work");

	// a result only comes out of a busy cycle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without a word in work");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped or changed under stall");

	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_W-1:1] == '0))
		else $error("result fill bits not zero");

endmodule

bind obb_overlap_test_core obbt_chk u_chk (.*);
